[design/assert_macros.svh]
// Assertion macros shared by the twin sieve prime test RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define TSP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define TSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/tsp_pkg.sv]
// Package for the twin sieve prime test: widths, register indexes,
// controller states and the command and status words. Depends on nothing.
`default_nettype none

package tsp_pkg;

   localparam int PRIME_WIDTH_DEF    = 62;
   localparam int EXPONENT_WIDTH_DEF = 32;
   localparam int K_WIDTH            = 62;
   localparam int BASE_WIDTH         = 32;
   localparam int JUDGE_WIDTH        = 64;
   localparam int CSR_DATA_WIDTH     = 64;
   localparam int CSR_ADDR_WIDTH     = 5;

   // register indexes (address bits 4:3)
   localparam logic [1:0] REG_BASE     = 2'd0;
   localparam logic [1:0] REG_EXPONENT = 2'd1;
   localparam logic [1:0] REG_MIN_K    = 2'd2;
   localparam logic [1:0] REG_MAX_K    = 2'd3;

   typedef enum logic [1:0] {
      DSEL_BASE,
      DSEL_EUCLID,
      DSEL_JUDGE_MINUS,
      DSEL_JUDGE_PLUS
   } div_sel_type;

   typedef enum logic [1:0] {
      MSEL_QS,
      MSEL_ACC,
      MSEL_SQR
   } mul_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_BASE,
      ST_EUC_TEST,
      ST_EUC_DIV,
      ST_EUC_MULGO,
      ST_EUC_MUL,
      ST_POW_TEST,
      ST_POW_ACC,
      ST_POW_SQRGO,
      ST_POW_SQR,
      ST_JDG_M,
      ST_JDG_MDIV,
      ST_JDG_P,
      ST_JDG_PDIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        pow_init;
      logic        judge_write;
      logic        judge_plus;
   } cmd_type;

   typedef struct packed {
      logic p_small;
      logic r1_zero;
      logic r0_one;
      logic e_zero;
      logic e_lsb;
      logic div_done;
      logic mul_done;
      logic need_div_minus;
      logic need_div_plus;
   } status_type;

   typedef struct packed {
      logic               hit;
      logic [K_WIDTH-1:0] k;
   } judge_type;

endpackage

`default_nettype wire

[design/tsp_divider.sv]
// Restoring divider, one quotient bit per cycle, for the twin sieve test.
// Depends on tsp_pkg for default widths.
`default_nettype none

module tsp_divider
   import tsp_pkg::*;
#(
   parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [((PRIME_WIDTH > K_WIDTH) ? PRIME_WIDTH : K_WIDTH)-1:0] dividend,
   input  wire logic [PRIME_WIDTH-1:0] divisor,
   output logic                        done,
   output logic [((PRIME_WIDTH > K_WIDTH) ? PRIME_WIDTH : K_WIDTH)-1:0] quot,
   output logic [PRIME_WIDTH-1:0]      rem
);

   localparam int DW = (PRIME_WIDTH > K_WIDTH) ? PRIME_WIDTH : K_WIDTH;
   localparam int CW = $clog2(DW + 1);

   logic                   busy_ff, busy_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [DW-1:0]          quot_ff, quot_in;
   logic [PRIME_WIDTH-1:0] rem_ff, rem_in;
   logic [PRIME_WIDTH-1:0] dsr_ff, dsr_in;
   logic [PRIME_WIDTH:0]   trial;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quot_ff[DW-1]};
      done    = busy_ff && (cnt_ff == '0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (trial >= {1'b0, dsr_ff}) begin
               rem_in  = PRIME_WIDTH'(trial - {1'b0, dsr_ff});
               quot_in = {quot_ff[DW-2:0], 1'b1};
            end else begin
               rem_in  = trial[PRIME_WIDTH-1:0];
               quot_in = {quot_ff[DW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

[design/tsp_mulmod.sv]
// Bit-serial modular multiplier (shift and add) for the twin sieve test.
// Depends on tsp_pkg for default widths.
`default_nettype none

module tsp_mulmod
   import tsp_pkg::*;
#(
   parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [PRIME_WIDTH-1:0] op_a,
   input  wire logic [PRIME_WIDTH-1:0] op_b,
   input  wire logic [PRIME_WIDTH-1:0] modulus,
   output logic                        done,
   output logic [PRIME_WIDTH-1:0]      product
);

   logic                   busy_ff, busy_in;
   logic [PRIME_WIDTH-1:0] acc_ff, acc_in;
   logic [PRIME_WIDTH-1:0] a_ff, a_in;
   logic [PRIME_WIDTH-1:0] b_ff, b_in;
   logic [PRIME_WIDTH-1:0] m_ff, m_in;
   logic [PRIME_WIDTH:0]   sum_acc, sum_dbl;

   // consume one multiplier bit a cycle; stop when none are left
   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      sum_acc = {1'b0, acc_ff} + {1'b0, a_ff};
      sum_dbl = {1'b0, a_ff} + {1'b0, a_ff};
      done    = busy_ff && (b_ff == '0);
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         m_in    = modulus;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = (sum_acc >= {1'b0, m_ff}) ? PRIME_WIDTH'(sum_acc - {1'b0, m_ff})
                                                  : sum_acc[PRIME_WIDTH-1:0];
            end
            a_in = (sum_dbl >= {1'b0, m_ff}) ? PRIME_WIDTH'(sum_dbl - {1'b0, m_ff})
                                             : sum_dbl[PRIME_WIDTH-1:0];
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

   assign product = acc_ff;

endmodule

`default_nettype wire

[design/tsp_datapath.sv]
// Datapath of the twin sieve test: Euclid, power and range registers
// around a shared divider and modular multiplier. Depends on tsp_pkg.
`default_nettype none

module tsp_datapath
   import tsp_pkg::*;
#(
   parameter int PRIME_WIDTH    = PRIME_WIDTH_DEF,
   parameter int EXPONENT_WIDTH = EXPONENT_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   input  wire logic [PRIME_WIDTH-1:0]    prime,
   input  wire logic [BASE_WIDTH-1:0]     base,
   input  wire logic [EXPONENT_WIDTH-1:0] exponent,
   input  wire logic [K_WIDTH-1:0]        min_k,
   input  wire logic [K_WIDTH-1:0]        max_k,
   output logic [PRIME_WIDTH-1:0]         tested,
   output judge_type                      minus_res,
   output judge_type                      plus_res
);

   localparam int DW = (PRIME_WIDTH > K_WIDTH) ? PRIME_WIDTH : K_WIDTH;

   logic [PRIME_WIDTH-1:0]    p_ff, r0_ff, r1_ff, s0_ff, s1_ff, q_ff, rt_ff, acc_ff, bb_ff;
   logic [EXPONENT_WIDTH-1:0] e_ff;
   div_sel_type               dsel_ff;
   mul_sel_type               msel_ff;
   judge_type                 minus_ff, plus_ff;

   logic [DW-1:0]          div_dividend, div_quot;
   logic [PRIME_WIDTH-1:0] div_divisor, div_rem, qm;
   logic                   div_done, mul_done;
   logic [PRIME_WIDTH-1:0] mul_a, mul_b, prod, st, c_plus, c_sel;
   logic [JUDGE_WIDTH-1:0] c_minus_w, c_plus_w, p_w, mn_w, mx_w, dvd_w;
   judge_type              jm_div, jp_div, jm_dir, jp_dir;

   // decide one side from candidate c and (min_k - c - 1) mod p
   function automatic judge_type judge(input logic [JUDGE_WIDTH-1:0] c,
                                       input logic [JUDGE_WIDTH-1:0] p,
                                       input logic [JUDGE_WIDTH-1:0] mn,
                                       input logic [JUDGE_WIDTH-1:0] mx,
                                       input logic [JUDGE_WIDTH-1:0] rem);
      judge_type              res;
      logic [JUDGE_WIDTH-1:0] raised;
      res    = '0;
      raised = mn - 1'b1 - rem + p;
      if (c <= mx) begin
         if (p <= mx) begin
            if (c < mn) begin
               if (raised <= mx) begin
                  res.hit = 1'b1;
                  res.k   = K_WIDTH'(raised);
               end
            end else begin
               res.hit = 1'b1;
               res.k   = K_WIDTH'(c);
            end
         end else if (c >= mn) begin
            res.hit = 1'b1;
            res.k   = K_WIDTH'(c);
         end
      end
      return res;
   endfunction

   // side candidates: k on the minus side, p - k on the plus side
   always_comb begin
      c_plus    = p_ff - acc_ff;
      c_minus_w = JUDGE_WIDTH'(acc_ff);
      c_plus_w  = JUDGE_WIDTH'(c_plus);
      p_w       = JUDGE_WIDTH'(p_ff);
      mn_w      = JUDGE_WIDTH'(min_k);
      mx_w      = JUDGE_WIDTH'(max_k);
      c_sel     = (cmd.div_sel == DSEL_JUDGE_PLUS) ? c_plus : acc_ff;
      dvd_w     = mn_w - JUDGE_WIDTH'(c_sel) - 1'b1;
      jm_div    = judge(c_minus_w, p_w, mn_w, mx_w, JUDGE_WIDTH'(div_rem));
      jp_div    = judge(c_plus_w, p_w, mn_w, mx_w, JUDGE_WIDTH'(div_rem));
      jm_dir    = judge(c_minus_w, p_w, mn_w, mx_w, '0);
      jp_dir    = judge(c_plus_w, p_w, mn_w, mx_w, '0);
   end

   // divider operand select
   always_comb begin
      div_dividend = DW'(r0_ff);
      div_divisor  = r1_ff;
      case (cmd.div_sel)
         DSEL_BASE: begin
            div_dividend = DW'(base);
            div_divisor  = p_ff;
         end
         DSEL_EUCLID: begin
            div_dividend = DW'(r0_ff);
            div_divisor  = r1_ff;
         end
         DSEL_JUDGE_MINUS, DSEL_JUDGE_PLUS: begin
            div_dividend = DW'(dvd_w);
            div_divisor  = p_ff;
         end
         default: begin
            div_dividend = DW'(r0_ff);
            div_divisor  = r1_ff;
         end
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = acc_ff;
      mul_b = bb_ff;
      case (cmd.mul_sel)
         MSEL_QS: begin
            mul_a = q_ff;
            mul_b = s1_ff;
         end
         MSEL_ACC: begin
            mul_a = acc_ff;
            mul_b = bb_ff;
         end
         MSEL_SQR: begin
            mul_a = bb_ff;
            mul_b = bb_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = bb_ff;
         end
      endcase
   end

   tsp_divider #(.PRIME_WIDTH(PRIME_WIDTH)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   tsp_mulmod #(.PRIME_WIDTH(PRIME_WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (p_ff),
      .done    (mul_done),
      .product (prod)
   );

   // quotient reduced mod p (it reaches p only when the divisor is one)
   assign qm = (div_quot == DW'(p_ff)) ? '0 : div_quot[PRIME_WIDTH-1:0];
   // next Bezout coefficient s0 - q*s1 mod p
   assign st = (s0_ff >= prod) ? s0_ff - prod : s0_ff + (p_ff - prod);

   // hold operand selects, load on commands and advance the registers on unit completion
   always_ff @(posedge clock) begin
      if (reset) begin
         dsel_ff <= DSEL_BASE;
         msel_ff <= MSEL_QS;
      end else begin
         if (cmd.div_start) begin
            dsel_ff <= cmd.div_sel;
         end
         if (cmd.mul_start) begin
            msel_ff <= cmd.mul_sel;
         end
      end
      if (cmd.load) begin
         p_ff     <= prime;
         minus_ff <= '0;
         plus_ff  <= '0;
      end
      if (cmd.pow_init) begin
         acc_ff <= PRIME_WIDTH'(1);
         bb_ff  <= s0_ff;
         e_ff   <= exponent;
      end
      if (cmd.judge_write) begin
         if (cmd.judge_plus) begin
            plus_ff <= jp_dir;
         end else begin
            minus_ff <= jm_dir;
         end
      end
      if (div_done) begin
         case (dsel_ff)
            DSEL_BASE: begin
               r0_ff <= p_ff;
               r1_ff <= div_rem;
               s0_ff <= '0;
               s1_ff <= PRIME_WIDTH'(1);
            end
            DSEL_EUCLID: begin
               q_ff  <= qm;
               rt_ff <= div_rem;
            end
            DSEL_JUDGE_MINUS: minus_ff <= jm_div;
            DSEL_JUDGE_PLUS:  plus_ff  <= jp_div;
            default: ;
         endcase
      end
      if (mul_done) begin
         case (msel_ff)
            MSEL_QS: begin
               r0_ff <= r1_ff;
               r1_ff <= rt_ff;
               s0_ff <= s1_ff;
               s1_ff <= st;
            end
            MSEL_ACC: acc_ff <= prod;
            MSEL_SQR: begin
               bb_ff <= prod;
               e_ff  <= e_ff >> 1;
            end
            default: ;
         endcase
      end
   end

   // status back to the controller
   always_comb begin
      status.p_small        = (p_ff < PRIME_WIDTH'(2));
      status.r1_zero        = (r1_ff == '0);
      status.r0_one         = (r0_ff == PRIME_WIDTH'(1));
      status.e_zero         = (e_ff == '0);
      status.e_lsb          = e_ff[0];
      status.div_done       = div_done;
      status.mul_done       = mul_done;
      status.need_div_minus = (c_minus_w <= mx_w) && (p_w <= mx_w) && (c_minus_w < mn_w);
      status.need_div_plus  = (c_plus_w <= mx_w) && (p_w <= mx_w) && (c_plus_w < mn_w);
   end

   assign tested    = p_ff;
   assign minus_res = minus_ff;
   assign plus_res  = plus_ff;

endmodule

`default_nettype wire

[design/tsp_ctrl.sv]
// Controller of the twin sieve test: sequences inverse, power and range
// steps on the datapath. Depends on tsp_pkg.
`default_nettype none

module tsp_ctrl
   import tsp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       out_free,
   output logic            finish,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd.load        = 1'b0;
      cmd.div_start   = 1'b0;
      cmd.div_sel     = DSEL_BASE;
      cmd.mul_start   = 1'b0;
      cmd.mul_sel     = MSEL_QS;
      cmd.pow_init    = 1'b0;
      cmd.judge_write = 1'b0;
      cmd.judge_plus  = 1'b0;
      req_ready       = 1'b0;
      finish          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.p_small) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_BASE;
               state_in      = ST_DIV_BASE;
            end
         end
         ST_DIV_BASE: begin
            if (status.div_done) begin
               state_in = ST_EUC_TEST;
            end
         end
         ST_EUC_TEST: begin
            if (!status.r1_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_EUCLID;
               state_in      = ST_EUC_DIV;
            end else if (status.r0_one) begin
               cmd.pow_init = 1'b1;
               state_in     = ST_POW_TEST;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EUC_DIV: begin
            if (status.div_done) begin
               state_in = ST_EUC_MULGO;
            end
         end
         ST_EUC_MULGO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_QS;
            state_in      = ST_EUC_MUL;
         end
         ST_EUC_MUL: begin
            if (status.mul_done) begin
               state_in = ST_EUC_TEST;
            end
         end
         ST_POW_TEST: begin
            if (status.e_zero) begin
               state_in = ST_JDG_M;
            end else if (status.e_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_ACC;
               state_in      = ST_POW_ACC;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_SQR;
               state_in      = ST_POW_SQR;
            end
         end
         ST_POW_ACC: begin
            if (status.mul_done) begin
               state_in = ST_POW_SQRGO;
            end
         end
         ST_POW_SQRGO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_SQR;
            state_in      = ST_POW_SQR;
         end
         ST_POW_SQR: begin
            if (status.mul_done) begin
               state_in = ST_POW_TEST;
            end
         end
         ST_JDG_M: begin
            if (status.need_div_minus) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_JUDGE_MINUS;
               state_in      = ST_JDG_MDIV;
            end else begin
               cmd.judge_write = 1'b1;
               state_in        = ST_JDG_P;
            end
         end
         ST_JDG_MDIV: begin
            if (status.div_done) begin
               state_in = ST_JDG_P;
            end
         end
         ST_JDG_P: begin
            cmd.div_sel = DSEL_JUDGE_PLUS;
            if (status.need_div_plus) begin
               cmd.div_start = 1'b1;
               state_in      = ST_JDG_PDIV;
            end else begin
               cmd.judge_write = 1'b1;
               cmd.judge_plus  = 1'b1;
               state_in        = ST_DONE;
            end
         end
         ST_JDG_PDIV: begin
            if (status.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/twin_sieve_prime_test.sv]
// Twin sieve prime test: one candidate prime at a time, one result word each.
// Each multiply stops after its second operand's bits; a stalled result holds input.
// Reset (synchronous, active high) idles the controller and loads the CSR defaults.
`default_nettype none

module twin_sieve_prime_test
   import tsp_pkg::*;
#(
   parameter int PRIME_WIDTH    = PRIME_WIDTH_DEF,
   parameter int EXPONENT_WIDTH = EXPONENT_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [K_WIDTH-1:0]        req_candidate_prime,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [K_WIDTH-1:0]             rsp_tested_prime,
   output logic                           rsp_minus_hit,
   output logic [K_WIDTH-1:0]             rsp_minus_k,
   output logic                           rsp_plus_hit,
   output logic [K_WIDTH-1:0]             rsp_plus_k,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0]      prdata,
   output logic                           pready
);

   `include "assert_macros.svh"

   logic [BASE_WIDTH-1:0] base_ff, exponent_ff;
   logic [K_WIDTH-1:0]    min_k_ff, max_k_ff;
   logic                  rsp_valid_ff;
   logic [K_WIDTH-1:0]    tested_ff, minus_k_ff, plus_k_ff;
   logic                  minus_hit_ff, plus_hit_ff;
   logic                  csr_write, out_free, finish;
   logic [1:0]            reg_index;
   cmd_type               cmd;
   status_type            status;
   logic [PRIME_WIDTH-1:0] tested;
   judge_type             minus_res, plus_res;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:3];
   assign csr_write = psel && penable && pwrite;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= BASE_WIDTH'(2);
         exponent_ff <= BASE_WIDTH'(1);
         min_k_ff    <= K_WIDTH'(1);
         max_k_ff    <= K_WIDTH'(1);
      end else if (csr_write) begin
         case (reg_index)
            REG_BASE:     base_ff     <= pwdata[BASE_WIDTH-1:0];
            REG_EXPONENT: exponent_ff <= pwdata[BASE_WIDTH-1:0];
            REG_MIN_K:    min_k_ff    <= pwdata[K_WIDTH-1:0];
            REG_MAX_K:    max_k_ff    <= pwdata[K_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // read back configuration registers
   always_comb begin
      case (reg_index)
         REG_BASE:     prdata = CSR_DATA_WIDTH'(base_ff);
         REG_EXPONENT: prdata = CSR_DATA_WIDTH'(exponent_ff);
         REG_MIN_K:    prdata = CSR_DATA_WIDTH'(min_k_ff);
         REG_MAX_K:    prdata = CSR_DATA_WIDTH'(max_k_ff);
         default:      prdata = '0;
      endcase
   end

   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .finish    (finish),
      .status    (status),
      .cmd       (cmd)
   );

   tsp_datapath #(
      .PRIME_WIDTH    (PRIME_WIDTH),
      .EXPONENT_WIDTH (EXPONENT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .prime     (PRIME_WIDTH'(req_candidate_prime)),
      .base      (base_ff),
      .exponent  (exponent_ff[EXPONENT_WIDTH-1:0]),
      .min_k     (min_k_ff),
      .max_k     (max_k_ff),
      .tested    (tested),
      .minus_res (minus_res),
      .plus_res  (plus_res)
   );

   // output register: load on finish, drop when taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (finish) begin
         tested_ff    <= K_WIDTH'(tested);
         minus_hit_ff <= minus_res.hit;
         minus_k_ff   <= minus_res.k;
         plus_hit_ff  <= plus_res.hit;
         plus_k_ff    <= plus_res.k;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tested_prime = tested_ff;
   assign rsp_minus_hit    = minus_hit_ff;
   assign rsp_minus_k      = minus_k_ff;
   assign rsp_plus_hit     = plus_hit_ff;
   assign rsp_plus_k       = plus_k_ff;

   `TSP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted a word while busy")
   `TSP_ASSERT_NOW(a_minus_miss_zero, clock, reset, rsp_valid && !rsp_minus_hit, rsp_minus_k == '0, "minus miss with nonzero k")
   `TSP_ASSERT_NOW(a_plus_miss_zero, clock, reset, rsp_valid && !rsp_plus_hit, rsp_plus_k == '0, "plus miss with nonzero k")
   `TSP_ASSERT_NOW(a_minus_in_range, clock, reset, rsp_valid && rsp_minus_hit, (rsp_minus_k >= min_k_ff) && (rsp_minus_k <= max_k_ff), "minus k out of range")
   `TSP_ASSERT_NOW(a_plus_in_range, clock, reset, rsp_valid && rsp_plus_hit, (rsp_plus_k >= min_k_ff) && (rsp_plus_k <= max_k_ff), "plus k out of range")

endmodule

`default_nettype wire
